// ----- sv/ethernet_ip_frame_classifier_top_assert.svh -----
// Assertion macros for the Ethernet/IP frame classifier.
// Sampled on clk; the checked module provides clk and rst_n.
`ifndef ETHERNET_IP_FRAME_CLASSIFIER_TOP_ASSERT_SVH
`define ETHERNET_IP_FRAME_CLASSIFIER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define EFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define EFC_ASSERT(label, prop, msg)
`define EFC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- sv/efc_pkg.sv -----
// Shared types and constants for the Ethernet/IP frame classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;

  localparam int MacW   = 48;
  localparam int CountW = 5;

  localparam logic [CountW-1:0] COUNT_MAX    = 5'd31;
  localparam logic [CountW-1:0] ETH_HDR_LEN  = 5'd14;
  localparam logic [CountW-1:0] VLAN_HDR_LEN = 5'd18;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] BCAST_BYTE = 8'hFF;
  localparam logic [7:0] V6MC_BYTE  = 8'h33;

  localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
  localparam logic [1:0] DIR_INBOUND  = 2'd1;
  localparam logic [1:0] DIR_OUTBOUND = 2'd2;

  // configuration register indexes
  localparam logic REG_OWN_MAC       = 1'b0;
  localparam logic REG_OWN_MAC_VALID = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       is_ip;
    logic [4:0] payload_offset;
    logic [1:0] direction;
  } out_t;

endpackage
`default_nettype wire

// ----- sv/efc_hdr.sv -----
// Header tracker: per-byte address matching, ethertype capture and the
// end-of-frame verdict. Depends on efc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module efc_hdr (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire efc_pkg::in_t             item,
  input  wire logic [efc_pkg::MacW-1:0] own_mac,
  input  wire logic                     own_mac_valid,
  output efc_pkg::out_t                 result
);

  logic [efc_pkg::CountW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic        dst_own_r, dst_own_nxt;
  logic        src_own_r, src_own_nxt;
  logic        dst_bc_r, dst_bc_nxt;
  logic        dst_mc_r, dst_mc_nxt;
  logic [15:0] outer_type_r, outer_type_nxt;
  logic [15:0] inner_type_r, inner_type_nxt;

  logic [2:0]  mac_idx;
  logic [7:0]  own_byte;
  logic [7:0]  b;
  logic [15:0] etype;
  logic [4:0]  pos;

  assign b   = item.data_byte;
  assign pos = byte_cnt_r;

  // address byte index 0..5 within either MAC field
  always_comb begin
    if (pos < 5'd6) begin
      mac_idx = pos[2:0];
    end else begin
      mac_idx = 3'(pos - 5'd6);
    end
  end

  always_comb begin
    unique case (mac_idx)
      3'd0:    own_byte = own_mac[47:40];
      3'd1:    own_byte = own_mac[39:32];
      3'd2:    own_byte = own_mac[31:24];
      3'd3:    own_byte = own_mac[23:16];
      3'd4:    own_byte = own_mac[15:8];
      default: own_byte = own_mac[7:0];
    endcase
  end

  always_comb begin
    dst_own_nxt    = dst_own_r;
    src_own_nxt    = src_own_r;
    dst_bc_nxt     = dst_bc_r;
    dst_mc_nxt     = dst_mc_r;
    outer_type_nxt = outer_type_r;
    inner_type_nxt = inner_type_r;
    if (pos < 5'd6) begin
      if (b != own_byte) dst_own_nxt = 1'b0;
      if (b != efc_pkg::BCAST_BYTE) dst_bc_nxt = 1'b0;
      if (pos < 5'd2 && b != efc_pkg::V6MC_BYTE) dst_mc_nxt = 1'b0;
    end else if (pos < 5'd12) begin
      if (b != own_byte) src_own_nxt = 1'b0;
    end else if (pos < 5'd14) begin
      outer_type_nxt = {outer_type_r[7:0], b};
    end else if (pos == 5'd16 || pos == 5'd17) begin
      inner_type_nxt = {inner_type_r[7:0], b};
    end
    byte_cnt_nxt = (byte_cnt_r < efc_pkg::COUNT_MAX) ? 5'(byte_cnt_r + 5'd1) : byte_cnt_r;
  end

  // verdict from the state including the current byte; frame length is pos + 1
  always_comb begin
    result.is_ip          = 1'b0;
    result.payload_offset = 5'd0;
    result.direction      = efc_pkg::DIR_UNKNOWN;
    etype                 = outer_type_nxt;
    if (pos >= efc_pkg::ETH_HDR_LEN) begin
      result.payload_offset = efc_pkg::ETH_HDR_LEN;
      if (outer_type_nxt == efc_pkg::TYPE_VLAN && pos >= efc_pkg::VLAN_HDR_LEN) begin
        etype                 = inner_type_nxt;
        result.payload_offset = efc_pkg::VLAN_HDR_LEN;
      end
      if (etype == efc_pkg::TYPE_IPV4 || etype == efc_pkg::TYPE_IPV6) begin
        result.is_ip = 1'b1;
        if (own_mac_valid) begin
          priority if (src_own_nxt) begin
            result.direction = efc_pkg::DIR_OUTBOUND;
          end else if (dst_own_nxt || dst_bc_nxt || dst_mc_nxt) begin
            result.direction = efc_pkg::DIR_INBOUND;
          end else begin
            result.direction = efc_pkg::DIR_UNKNOWN;
          end
        end
      end else begin
        result.payload_offset = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      byte_cnt_r   <= '0;
      dst_own_r    <= 1'b1;
      src_own_r    <= 1'b1;
      dst_bc_r     <= 1'b1;
      dst_mc_r     <= 1'b1;
      outer_type_r <= '0;
      inner_type_r <= '0;
    end else if (step) begin
      byte_cnt_r   <= byte_cnt_nxt;
      dst_own_r    <= dst_own_nxt;
      src_own_r    <= src_own_nxt;
      dst_bc_r     <= dst_bc_nxt;
      dst_mc_r     <= dst_mc_nxt;
      outer_type_r <= outer_type_nxt;
      inner_type_r <= inner_type_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ethernet_ip_frame_classifier_top.sv -----
// Ethernet/IP frame classifier, one frame byte per transfer.
// The last byte passes the input register and its result the result register.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while an earlier result is still stalled in the result register.
// Reset (rst_n low, synchronous) empties both registers, clears frame state
// and sets own_mac to zero and own_mac_valid to 0.
`timescale 1ns / 1ps
`default_nettype none
`include "ethernet_ip_frame_classifier_top_assert.svh"
module ethernet_ip_frame_classifier_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire efc_pkg::in_t             in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output efc_pkg::out_t                 out_data,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_index,
  input  wire logic [efc_pkg::MacW-1:0] cfg_wdata
);

  logic [efc_pkg::MacW-1:0] own_mac_r;
  logic                     own_mac_valid_r;

  logic          in_valid_r;
  efc_pkg::in_t  in_r;
  logic          out_valid_r;
  efc_pkg::out_t out_r;
  efc_pkg::out_t res;

  logic in_xfer;
  logic s1_go;

  // a non-last byte always moves on; a last byte needs room in the result register
  assign s1_go    = in_valid_r && (!in_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r       <= '0;
      own_mac_valid_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        efc_pkg::REG_OWN_MAC:       own_mac_r       <= cfg_wdata;
        efc_pkg::REG_OWN_MAC_VALID: own_mac_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (s1_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
  end

  efc_hdr u_hdr (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_go),
    .item          (in_r),
    .own_mac       (own_mac_r),
    .own_mac_valid (own_mac_valid_r),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && in_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && in_r.last_byte) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `EFC_ASSERT(a_not_ip_clean, out_valid_r && !out_r.is_ip |-> out_r.payload_offset == 5'd0 && out_r.direction == efc_pkg::DIR_UNKNOWN, "non-IP result carries offset or direction")
  `EFC_ASSERT(a_ip_offset, out_valid_r && out_r.is_ip |-> out_r.payload_offset == efc_pkg::ETH_HDR_LEN || out_r.payload_offset == efc_pkg::VLAN_HDR_LEN, "IP result with bad offset")
  `EFC_ASSERT(a_last_held, in_valid_r && in_r.last_byte && out_valid_r && out_stall |=> in_valid_r && in_r.last_byte, "last byte lost while result register full")
  `EFC_ASSERT(a_no_overwrite, out_valid_r && out_stall |=> out_valid_r && $stable(out_r), "stalled result overwritten")
  `EFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !in_valid_r, "registers not empty after reset")

endmodule
`default_nettype wire
